### rtl/rotated_sorted_array_search_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotated sorted array search core
// Implication checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ROTATED_SORTED_ARRAY_SEARCH_CORE_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RSAS_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("rsas: same-cycle check failed");
`define RSAS_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("rsas: next-cycle check failed");
`else
`define RSAS_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define RSAS_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

### rtl/rsas_pkg.sv
// ----------------------------------------------------------------------------
// rsas_pkg
// Item types, opcodes and default sizes of the rotated sorted array search.
// ----------------------------------------------------------------------------
package rsas_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// Opcodes of an input item.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [5:0]         entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] search_key;
		logic [6:0]         entry_count;
	} rsas_in_t;

	typedef struct packed {
		logic       found;
		logic [5:0] found_index;
	} rsas_out_t;

endpackage

### rtl/rsas_ram.sv
// ----------------------------------------------------------------------------
// rsas_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rsas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/rotated_sorted_array_search_core.sv
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_core
// Table of signed words with a pivot search and a binary search on request.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   --------  ---------  ---------------------  -----------------------------
//   in_item   input      in_valid / in_stall    opcode, index, value, key, count
//   out_item  output     out_valid / out_stall  found, found_index
//
// A write item gives no result; writes can follow each other back to back.
// A search item runs the pivot search, tests the pivot and, unless it holds
// the key, entry zero, takes its binary steps and then posts the result. The
// single read port of the table RAM, with its registered read, sets the pace:
// every entry compared costs one read.
// Reset clears the sequencer, the output register and the search registers;
// the table holds no value until it is written, so there is no clearing pass.
// A result waits in the output register while out_stall is high; a finished
// search holds in its last state until that register is free.
//
module rotated_sorted_array_search_core
	import rsas_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  rsas_in_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output rsas_out_t out_item
);

	`include "rotated_sorted_array_search_core_assert.svh"

	// Address width of the table, and a signed index width that holds -1 and
	// also the sum of two indices without overflow.
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int SW = IW + 2;

	localparam logic signed [SW-1:0] IDX_ONE  = SW'(1);
	localparam logic signed [SW-1:0] IDX_ZERO = '0;
	localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_CHK,
		ST_P_RA,
		ST_P_RB,
		ST_P_RC,
		ST_P_RD,
		ST_PV_R,
		ST_PV_D,
		ST_Z_D,
		ST_B_CHK,
		ST_B_D,
		ST_FIN
	} state_t;

	// Reduce a six-bit write index modulo the table depth by restoring
	// subtraction of shifted copies of the depth.
	function automatic logic [IW-1:0] wrap_index(input logic [5:0] idx);
		int t;
		int k;
		t = int'(idx);
		for (k = 5; k >= 0; k--) begin
			if (t >= (TABLE_DEPTH << k)) begin
				t = t - (TABLE_DEPTH << k);
			end
		end
		return IW'(t);
	endfunction

	state_t                  state_q;
	logic                    out_valid_q;
	rsas_out_t               out_q;
	logic signed [SW-1:0]    lo_q;
	logic signed [SW-1:0]    hi_q;
	logic signed [SW-1:0]    mid_q;
	logic signed [SW-1:0]    pv_q;
	logic signed [SW-1:0]    n_q;
	logic [VALUE_WIDTH-1:0]  key_q;
	logic [VALUE_WIDTH-1:0]  vm_q;
	logic                    found_q;
	logic [IW-1:0]           res_q;

	logic                    in_acc;
	logic                    ram_we;
	logic [IW-1:0]           ram_waddr;
	logic [VALUE_WIDTH-1:0]  ram_wdata;
	logic                    ram_re;
	logic signed [SW-1:0]    rd_idx;
	logic [VALUE_WIDTH-1:0]  ram_rdata;
	logic signed [SW-1:0]    sum_c;
	logic signed [SW-1:0]    mid_c;
	logic signed [SW-1:0]    cnt_c;
	logic [VALUE_WIDTH-1:0]  key_c;
	logic                    out_free;

	// Shared compare unit: the held key or the held middle entry against the
	// word that the RAM returns this cycle. Values are kept in order-key form
	// (sign bit flipped) so an unsigned compare gives the signed order.
	logic [VALUE_WIDTH-1:0]  cmp_a;
	logic                    cmp_eq;
	logic                    cmp_gt;
	logic                    cmp_lt;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Write port: taken straight from an accepted write item.
	assign ram_we    = in_acc && (in_item.opcode == OP_WRITE);
	assign ram_waddr = wrap_index(in_item.entry_index);
	assign ram_wdata = VALUE_WIDTH'(in_item.entry_value) ^ SIGN_FLIP;
	assign key_c     = VALUE_WIDTH'(in_item.search_key) ^ SIGN_FLIP;

	// The count saturates at the table depth.
	assign cnt_c = (int'(in_item.entry_count) > TABLE_DEPTH) ? SW'(TABLE_DEPTH)
		: SW'(in_item.entry_count);

	// Both bounds are never negative when a middle is taken.
	assign sum_c = lo_q + hi_q;
	assign mid_c = sum_c >>> 1;

	assign cmp_a  = ((state_q == ST_PV_D) || (state_q == ST_Z_D) || (state_q == ST_B_D))
		? key_q : vm_q;
	assign cmp_eq = (cmp_a == ram_rdata);
	assign cmp_gt = (cmp_a > ram_rdata);
	assign cmp_lt = !cmp_eq && !cmp_gt;

	// Read address of each state; the registered word comes back in the next cycle.
	always_comb begin
		ram_re = 1'b1;
		case (state_q)
			ST_P_CHK: rd_idx = mid_c;
			ST_P_RA:  rd_idx = mid_q + IDX_ONE;
			ST_P_RB:  rd_idx = mid_q - IDX_ONE;
			ST_P_RC:  rd_idx = lo_q;
			ST_PV_R:  rd_idx = pv_q;
			ST_PV_D:  rd_idx = IDX_ZERO;
			ST_B_CHK: rd_idx = mid_c;
			default: begin
				rd_idx = IDX_ZERO;
				ram_re = 1'b0;
			end
		endcase
	end

	rsas_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_idx[IW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			pv_q        <= '0;
			n_q         <= '0;
			key_q       <= '0;
			vm_q        <= '0;
			found_q     <= 1'b0;
			res_q       <= '0;
		end else begin
			// A taken result leaves the register unless a new one is posted
			// in the same cycle.
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_item.opcode == OP_SEARCH)) begin
						key_q   <= key_c;
						n_q     <= cnt_c;
						lo_q    <= IDX_ZERO;
						hi_q    <= cnt_c - IDX_ONE;
						state_q <= ST_P_CHK;
					end
				end
				// Pivot search: test the range, then fetch middle, middle+1,
				// middle-1 and the low end, one word per cycle.
				ST_P_CHK: begin
					if (hi_q < lo_q) begin
						// No pivot: search the whole used range.
						lo_q    <= IDX_ZERO;
						hi_q    <= n_q - IDX_ONE;
						state_q <= ST_B_CHK;
					end else if (hi_q == lo_q) begin
						pv_q    <= lo_q;
						state_q <= ST_PV_R;
					end else begin
						mid_q   <= mid_c;
						state_q <= ST_P_RA;
					end
				end
				ST_P_RA: begin
					vm_q    <= ram_rdata;
					state_q <= ST_P_RB;
				end
				ST_P_RB: begin
					if ((mid_q < hi_q) && cmp_gt) begin
						pv_q    <= mid_q;
						state_q <= ST_PV_R;
					end else begin
						state_q <= ST_P_RC;
					end
				end
				ST_P_RC: begin
					if ((mid_q > lo_q) && cmp_lt) begin
						pv_q    <= mid_q - IDX_ONE;
						state_q <= ST_PV_R;
					end else begin
						state_q <= ST_P_RD;
					end
				end
				ST_P_RD: begin
					if (!cmp_gt) begin
						hi_q <= mid_q - IDX_ONE;
					end else begin
						lo_q <= mid_q + IDX_ONE;
					end
					state_q <= ST_P_CHK;
				end
				ST_PV_R: begin
					state_q <= ST_PV_D;
				end
				// The pivot entry itself may be the key; otherwise entry zero
				// picks the half for the binary search.
				ST_PV_D: begin
					if (cmp_eq) begin
						found_q <= 1'b1;
						res_q   <= pv_q[IW-1:0];
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_Z_D;
					end
				end
				ST_Z_D: begin
					if (!cmp_lt) begin
						lo_q <= IDX_ZERO;
						hi_q <= pv_q - IDX_ONE;
					end else begin
						lo_q <= pv_q + IDX_ONE;
						hi_q <= n_q - IDX_ONE;
					end
					state_q <= ST_B_CHK;
				end
				ST_B_CHK: begin
					if (lo_q > hi_q) begin
						found_q <= 1'b0;
						res_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						mid_q   <= mid_c;
						state_q <= ST_B_D;
					end
				end
				ST_B_D: begin
					if (cmp_eq) begin
						found_q <= 1'b1;
						res_q   <= mid_q[IW-1:0];
						state_q <= ST_FIN;
					end else begin
						if (cmp_gt) begin
							lo_q <= mid_q + IDX_ONE;
						end else begin
							hi_q <= mid_q - IDX_ONE;
						end
						state_q <= ST_B_CHK;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q       <= 1'b1;
						out_q.found       <= found_q;
						out_q.found_index <= 6'(res_q);
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A search item always makes the block busy in the next cycle.
	`RSAS_ASSERT_NXT(a_search_busy, clk, arst_n, in_acc && (in_item.opcode == OP_SEARCH), in_stall)
	// A write item never leaves the block busy.
	`RSAS_ASSERT_NXT(a_write_idle, clk, arst_n, in_acc && (in_item.opcode == OP_WRITE), !in_stall)
	// A taken result is gone in the next cycle unless a new one is posted.
	`RSAS_ASSERT_NXT(a_no_extra, clk, arst_n, out_valid && !out_stall && (state_q != ST_FIN), !out_valid)
	// Binary search bounds are never negative while an entry is compared.
	`RSAS_ASSERT_IMP(a_bounds, clk, arst_n, state_q == ST_B_D, !lo_q[SW-1] && !hi_q[SW-1])

endmodule

### tb/rotated_sorted_array_search_core_tb.sv
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_core_tb
// Self-checking bench for the rotated sorted array search core. A mirror of
// the table predicts every search answer. Stimulus is mostly rotated sorted
// tables with searches into them, plus scattered writes and arbitrary keys
// and counts. Both channels idle, stall and hold off at random.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_core_tb
	import rsas_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 64;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 390;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	rsas_in_t  in_item   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	rsas_out_t out_item;

	// Mirror of the table as the block should hold it, updated when a write
	// item is accepted. Searches are predicted against it at acceptance.
	logic signed [31:0] table_mirror [DEPTH];
	rsas_out_t          search_answers_due [$];

	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int hold_request    = 0;
	int hold_left       = 0;
	int items_sent      = 0;
	int searches_sent   = 0;
	int answers_checked = 0;
	int errors          = 0;
	int cycle_count     = 0;

	rotated_sorted_array_search_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog. A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d answers outstanding",
				$time, search_answers_due.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Prediction. The pivot search halves [lo, hi] until it sees a descent or
	// runs out of range; the answer search is an ordinary binary search. All
	// comparisons are signed, which is the order the block uses.
	// ------------------------------------------------------------------------
	function automatic int pivot_of(input int lo_in, input int hi_in);
		int lo;
		int hi;
		int mid;
		lo = lo_in;
		hi = hi_in;
		while (1) begin
			if (hi < lo)
				return -1;
			if (hi == lo)
				return lo;
			mid = (lo + hi) / 2;
			if (mid < hi && table_mirror[mid] > table_mirror[mid + 1])
				return mid;
			if (mid > lo && table_mirror[mid] < table_mirror[mid - 1])
				return mid - 1;
			if (table_mirror[lo] >= table_mirror[mid])
				hi = mid - 1;
			else
				lo = mid + 1;
		end
	endfunction

	function automatic int position_of(input int lo_in, input int hi_in,
			input logic signed [31:0] key);
		int lo;
		int hi;
		int mid;
		lo = lo_in;
		hi = hi_in;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (key == table_mirror[mid])
				return mid;
			if (key > table_mirror[mid])
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return -1;
	endfunction

	function automatic rsas_out_t predict_search(input logic signed [31:0] key,
			input logic [6:0] count);
		int n;
		int pivot;
		int hit;
		rsas_out_t answer;
		// Counts past the table depth behave as a full table.
		n = (count > DEPTH) ? DEPTH : int'(count);
		pivot = pivot_of(0, n - 1);
		if (pivot < 0)
			hit = position_of(0, n - 1, key);
		else if (table_mirror[pivot] == key)
			hit = pivot;
		else if (table_mirror[0] <= key)
			hit = position_of(0, pivot - 1, key);
		else
			hit = position_of(pivot + 1, n - 1, key);
		answer.found       = (hit >= 0);
		answer.found_index = (hit >= 0) ? hit[5:0] : 6'd0;
		return answer;
	endfunction

	// ------------------------------------------------------------------------
	// Input side. The payload is driven at the rising edge and held until the
	// block takes it. The stall is sampled at the falling edge, where it is
	// settled, so the following rising edge is known to be the handshake.
	// in_valid is left high on return; whoever advances time next decides
	// whether it drops, so it never gets two assignments in one step.
	// ------------------------------------------------------------------------
	task automatic send_item(input rsas_in_t item);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item  <= item;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		items_sent++;
		if (item.opcode == OP_WRITE) begin
			table_mirror[item.entry_index] = item.entry_value;
		end else begin
			search_answers_due.push_back(predict_search(item.search_key,
				item.entry_count));
			searches_sent++;
		end
	endtask

	// Fields that an operation does not use are filled at random so that
	// every bit of the item toggles.
	task automatic send_write(input logic [5:0] index, input logic signed [31:0] value);
		rsas_in_t item;
		item.opcode      = OP_WRITE;
		item.entry_index = index;
		item.entry_value = value;
		item.search_key  = $urandom;
		item.entry_count = 7'($urandom);
		send_item(item);
	endtask

	task automatic send_search(input logic signed [31:0] key, input logic [6:0] count);
		rsas_in_t item;
		item.opcode      = OP_SEARCH;
		item.entry_index = 6'($urandom);
		item.entry_value = $urandom;
		item.search_key  = key;
		item.entry_count = count;
		send_item(item);
	endtask

	// Drops in_valid and waits until every search sent so far
	// has been answered.
	task automatic wait_for_answers();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (search_answers_due.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Output side. A long hold-off, when requested, is counted down here;
	// otherwise the stall follows the current percentage.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Results are compared at the falling edge before their handshake, when
	// valid, stall and the payload are all settled.
	always @(negedge clk) begin
		rsas_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (search_answers_due.size() == 0) begin
				errors++;
				$display("%0t: result found=%0b index=%0d with no search outstanding",
					$time, out_item.found, out_item.found_index);
			end else begin
				want = search_answers_due.pop_front();
				answers_checked++;
				if (out_item.found !== want.found) begin
					errors++;
					$display("%0t: found expected %0b, got %0b",
						$time, want.found, out_item.found);
				end
				if (out_item.found_index !== want.found_index) begin
					errors++;
					$display("%0t: found_index expected %0d, got %0d",
						$time, want.found_index, out_item.found_index);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus building blocks.
	// ------------------------------------------------------------------------

	// Loads entries 0..n-1 with a rotated, strictly increasing run and then
	// searches it. Wide runs spread over the whole signed range; narrow runs
	// sit near zero with small steps so that absent keys land between values.
	task automatic rotated_sequence();
		logic signed [31:0] run [DEPTH];
		logic signed [31:0] key;
		logic [6:0]         count;
		longint             base;
		longint             step;
		int                 n;
		int                 rot;
		int                 k;
		int                 searches;
		n = ($urandom_range(7) == 0) ? $urandom_range(17, DEPTH) : $urandom_range(1, 16);
		if ($urandom_range(1)) begin
			step = 64'h1_0000_0000 / n;
			base = -64'sh8000_0000;
		end else begin
			step = $urandom_range(1, 6);
			base = longint'($urandom_range(400)) - 200;
		end
		// Each value sits in its own bucket of width step, so all are distinct.
		for (k = 0; k < n; k++)
			run[k] = 32'(base + k * step + longint'($urandom_range(32'(step - 1))));
		rot = $urandom_range(n - 1);
		if ($urandom_range(1)) begin
			for (k = 0; k < n; k++)
				send_write(6'(k), run[(k + rot) % n]);
		end else begin
			for (k = n - 1; k >= 0; k--)
				send_write(6'(k), run[(k + rot) % n]);
		end
		searches = $urandom_range(1, 6);
		for (k = 0; k < searches; k++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: key = run[$urandom_range(n - 1)];
				5:             key = run[$urandom_range(n - 1)] + 1;
				6:             key = run[$urandom_range(n - 1)] - 1;
				7:             key = $urandom;
				8:             key = 32'sh8000_0000;
				default:       key = 32'sh7fff_ffff;
			endcase
			count = ($urandom_range(4) == 0) ? 7'($urandom) : 7'(n);
			send_search(key, count);
		end
	endtask

	// Scattered writes that break the ordering, and searches with arbitrary
	// keys and counts against whatever the table holds.
	task automatic noise_burst();
		int n;
		int k;
		n = $urandom_range(2, 8);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(3))
				0, 1: send_write(6'($urandom), $urandom);
				2:    send_search(table_mirror[$urandom_range(DEPTH - 1)], 7'($urandom));
				default: send_search($urandom, 7'($urandom));
			endcase
		end
	endtask

	task automatic random_phase(input int idle_pct, input int stall_pct);
		int first;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		first = items_sent;
		while (items_sent - first < PHASE_ITEMS) begin
			if ($urandom_range(9) == 0)
				noise_burst();
			else
				rotated_sequence();
		end
		wait_for_answers();
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Writes all 64 entries before any search, so no search can ever touch an
	// entry that holds nothing. The run climbs from the most negative to the
	// most positive value and is rotated so the wrap sits at entries 42/43.
	task automatic test_table_fill();
		logic signed [31:0] run [DEPTH];
		int k;
		for (k = 0; k < DEPTH; k++)
			run[k] = -3200 + k * 100;
		run[0]         = 32'sh8000_0000;
		run[DEPTH - 1] = 32'sh7fff_ffff;
		for (k = 0; k < DEPTH; k++)
			send_write(6'(k), run[(k + 21) % DEPTH]);
	endtask

	task automatic test_directed();
		// An empty count finds nothing, even for a key that is present.
		send_search(table_mirror[5], 7'd0);
		// Both extremes, which also sit on either side of the wrap.
		send_search(32'sh8000_0000, 7'd64);
		send_search(32'sh7fff_ffff, 7'd64);
		send_search(32'sh8000_0001, 7'd64);
		// First and last entries, one in each half, and the largest count,
		// which must behave as a full table.
		send_search(table_mirror[0], 7'd127);
		send_search(table_mirror[63], 7'd64);
		send_search(table_mirror[5], 7'd64);
		send_search(table_mirror[55], 7'd100);
		// Keys that fall between stored values or below every ordinary one.
		send_search(-32'sd2199, 7'd64);
		send_search(-32'sd5000, 7'd64);
		// A one-entry table.
		send_search(table_mirror[0], 7'd1);
		send_search(table_mirror[1], 7'd1);
		// Break the ordering with a repeated maximum and a stray value; the
		// block must still end inside the count.
		send_write(6'h3f, 32'sh7fff_ffff);
		send_write(6'd10, -32'sd1);
		send_search(32'sh7fff_ffff, 7'd64);
		send_search(-32'sd1, 7'd64);
		send_search(table_mirror[20], 7'd64);
		wait_for_answers();
	endtask

	task automatic test_no_idle();
		random_phase(0, 0);
	endtask

	task automatic test_sender_idle();
		random_phase(73, 0);
	endtask

	task automatic test_receiver_stall();
		random_phase(0, 73);
	endtask

	task automatic test_both_idle();
		random_phase(21, 21);
	endtask

	// The receiver holds off for a long stretch while searches keep coming,
	// so the output register fills, the search engine parks and the input
	// stalls. The hold is counted down by the stall process.
	task automatic test_long_hold();
		int k;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (k = 0; k < 32; k++)
			send_write(6'(k), -32'sd1000 + ((k + 9) % 32) * 7);
		hold_request = 400;
		for (k = 0; k < 24; k++)
			send_search(table_mirror[$urandom_range(31)] + $urandom_range(1), 7'd32);
		wait_for_answers();
	endtask

	// One search at a time: the sender pauses until each answer is back, so
	// every search starts on a quiet block.
	task automatic test_drain_pause();
		int k;
		send_idle_pct  = 0;
		recv_stall_pct = 30;
		for (k = 0; k < 8; k++) begin
			send_search(table_mirror[$urandom_range(DEPTH - 1)], 7'($urandom_range(1, 127)));
			wait_for_answers();
		end
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_fill();
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_long_hold();
		test_drain_pause();

		// Let any late or stray result show up before the verdict.
		recv_stall_pct = 0;
		wait_for_answers();
		repeat (100) @(posedge clk);

		$display("Sent %0d items (%0d searches); checked %0d answers.",
			items_sent, searches_sent, answers_checked);
		$display("Covered rotated and broken tables, all counts, and idle, stall and hold-off.");
		if (errors == 0 && search_answers_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
